// ----- rtl/sacl_pkg.sv -----
// Shared codes for the set-associative cache simulator: register indexes, record kinds, outcomes, defaults.
package sacl_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [1:0] CFG_WAYS       = 2'd1;
	localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

	// Record kinds.
	localparam logic [1:0] MODE_OTHER  = 2'd0;
	localparam logic [1:0] MODE_LOAD   = 2'd1;
	localparam logic [1:0] MODE_STORE  = 2'd2;
	localparam logic [1:0] MODE_MODIFY = 2'd3;

	// Access outcomes.
	localparam logic [1:0] OUT_HIT   = 2'd0;
	localparam logic [1:0] OUT_MISS  = 2'd1;
	localparam logic [1:0] OUT_EVICT = 2'd2;

	// Parameter defaults.
	localparam int DEF_MAX_WAYS     = 8;
	localparam int DEF_MAX_SET_BITS = 6;
	localparam int DEF_ADDR_WIDTH   = 32;
	localparam int DEF_AGE_WIDTH    = 16;

endpackage

// ----- rtl/sacl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/set_assoc_cache_lru_sim.sv -----
// Top level of the set-associative cache simulator with least-recently-used replacement.
//
//  Channel   Direction  Signals                    Contents (lowest bit first)
//  s_axis    in         tvalid/tready/tdata/tuser  tdata: address[31:0]; tuser: mode[1:0]
//  m_axis    out        tvalid/tready/tdata/tuser  tdata: hit_count, miss_count,
//                       /tlast                     eviction_count; tuser: outcome; tlast: last
//  cfg       in         cfg_we/cfg_index/cfg_data  set_bits, ways, block_bits
//
// A request is taken in the idle state. Each access reads and then compares one way at a time
// through the single line RAM port and the shared tag and age comparator, stopping at a hit,
// and then hands its result over. A modify makes two accesses, a load or store one and a record
// with no access none; a background scrub read and write of one line close every request.
// After reset a clearing pass over all 2^MAX_SET_BITS * MAX_WAYS lines empties the line RAM;
// no request is taken during it. A result waiting on m_axis stalls the block in its hand-over
// state, so neither the second access of a modify nor the closing scrub starts until the
// result has been taken.
module set_assoc_cache_lru_sim
	import sacl_pkg::*;
#(
	parameter int MAX_WAYS     = DEF_MAX_WAYS,
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH,
	parameter int AGE_WIDTH    = DEF_AGE_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // address[31:0]
	input  logic [1:0]   s_axis_tuser,   // mode[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,   // hit_count, miss_count, eviction_count
	output logic [1:0]   m_axis_tuser,   // outcome[1:0]
	output logic         m_axis_tlast,   // last
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [4:0]   cfg_data
);

	localparam int NUM_LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
	localparam int IDX_W     = NUM_LINES > 1 ? $clog2(NUM_LINES) : 1;
	localparam int WAY_W     = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
	localparam int SET_W     = MAX_SET_BITS > 0 ? MAX_SET_BITS : 1;
	// Lines carry the record number of their last use; the age is the distance to the
	// current record number. The scrubber marks a line saturated before that distance
	// can wrap, so the stamp only needs room for the age limit plus one scrub period.
	localparam int STAMP_W   = AGE_WIDTH + IDX_W + 1;
	localparam int ENT_W     = ADDR_WIDTH + STAMP_W + 2;
	localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_CHECK, ST_WAIT, ST_SCRUB_RD, ST_SCRUB_WR
	} state_t;

	state_t state_q;

	logic [2:0]            set_bits_q;
	logic [3:0]            ways_q;
	logic [4:0]            block_bits_q;

	logic [IDX_W-1:0]      ptr_q;       // clearing and scrubbing pointer
	logic [IDX_W-1:0]      base_q;
	logic [ADDR_WIDTH-1:0] tag_q;
	logic [WAY_W-1:0]      way_q;
	logic [WAY_W-1:0]      way_last_q;
	logic                  second_q;
	logic                  inv_found_q;
	logic [WAY_W-1:0]      inv_way_q;
	logic [WAY_W-1:0]      best_way_q;
	logic [AGE_WIDTH-1:0]  best_age_q;
	logic [STAMP_W-1:0]    now_q;

	logic [31:0]           hits_q;
	logic [31:0]           misses_q;
	logic [31:0]           evicts_q;
	logic                  out_valid_q;
	logic [1:0]            out_outcome_q;
	logic                  out_last_q;

	// Line RAM.
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [ENT_W-1:0]      ram_wdata;
	logic [IDX_W-1:0]      ram_raddr;
	logic [ENT_W-1:0]      ram_rdata;

	sacl_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_LINES)
	) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Fields of the entry just read.
	logic                  r_valid;
	logic                  r_sat;
	logic [STAMP_W-1:0]    r_stamp;
	logic [ADDR_WIDTH-1:0] r_tag;
	logic [STAMP_W-1:0]    r_diff;
	logic                  r_old;
	logic [AGE_WIDTH-1:0]  r_age;

	assign r_valid = ram_rdata[ENT_W-1];
	assign r_sat   = ram_rdata[ENT_W-2];
	assign r_stamp = ram_rdata[ADDR_WIDTH +: STAMP_W];
	assign r_tag   = ram_rdata[ADDR_WIDTH-1:0];
	assign r_diff  = now_q - r_stamp;
	assign r_old   = r_diff >= STAMP_W'(AGE_MAX);
	assign r_age   = (r_sat || r_old) ? AGE_MAX : r_diff[AGE_WIDTH-1:0];

	// Address split of the incoming request.
	logic [ADDR_WIDTH-1:0] in_addr;
	logic [2:0]            s_eff;
	logic [5:0]            bs_sum;
	logic [ADDR_WIDTH-1:0] set_shift;
	logic [SET_W-1:0]      set_idx;
	logic [ADDR_WIDTH-1:0] in_tag;
	logic [WAY_W-1:0]      in_way_last;

	always_comb begin
		in_addr   = s_axis_tdata[ADDR_WIDTH-1:0];
		s_eff     = (int'(set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;
		bs_sum    = 6'(block_bits_q) + 6'(s_eff);
		set_shift = (int'(block_bits_q) < ADDR_WIDTH) ? (in_addr >> block_bits_q) : '0;
		set_idx   = set_shift[SET_W-1:0] & SET_W'((1 << s_eff) - 1);
		in_tag    = (int'(bs_sum) < ADDR_WIDTH) ? (in_addr >> bs_sum) : '0;
		if (ways_q == 4'd0) begin
			in_way_last = '0;
		end else if (int'(ways_q) > MAX_WAYS) begin
			in_way_last = WAY_W'(MAX_WAYS - 1);
		end else begin
			in_way_last = WAY_W'(ways_q - 4'd1);
		end
	end

	// Decision of the compare cycle.
	logic             hit_now;
	logic             done_now;
	logic             inv_any;
	logic [WAY_W-1:0] inv_way;
	logic [WAY_W-1:0] best_way;
	logic [AGE_WIDTH-1:0] best_age;
	logic [WAY_W-1:0] pick_way;
	logic [1:0]       outcome;

	always_comb begin
		hit_now = r_valid && (r_tag == tag_q);
		inv_any = inv_found_q || !r_valid;
		inv_way = inv_found_q ? inv_way_q : way_q;
		if (way_q == '0 || r_age > best_age_q) begin
			best_way = way_q;
			best_age = r_age;
		end else begin
			best_way = best_way_q;
			best_age = best_age_q;
		end
		done_now = hit_now || (way_q == way_last_q);
		if (hit_now) begin
			pick_way = way_q;
			outcome  = OUT_HIT;
		end else if (inv_any) begin
			pick_way = inv_way;
			outcome  = OUT_MISS;
		end else begin
			pick_way = best_way;
			outcome  = OUT_EVICT;
		end
	end

	// RAM port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = '0;
		ram_raddr = ptr_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_READ: begin
				ram_raddr = IDX_W'(base_q + IDX_W'(way_q));
			end
			ST_CHECK: begin
				ram_we    = done_now;
				ram_waddr = IDX_W'(base_q + IDX_W'(pick_way));
				ram_wdata = {1'b1, 1'b0, now_q, tag_q};
			end
			ST_SCRUB_WR: begin
				ram_we    = r_valid && !r_sat && r_old;
				ram_wdata = {1'b1, 1'b1, r_stamp, r_tag};
			end
			default: begin
			end
		endcase
	end

	function automatic logic [31:0] sat_inc(input logic [31:0] x);
		sat_inc = (x == '1) ? x : x + 32'd1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			set_bits_q   <= 3'd0;
			ways_q       <= 4'd1;
			block_bits_q <= 5'd0;
			ptr_q        <= '0;
			now_q        <= '0;
			hits_q       <= '0;
			misses_q     <= '0;
			evicts_q     <= '0;
			out_valid_q  <= 1'b0;
			second_q     <= 1'b0;
			inv_found_q  <= 1'b0;
			way_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
					CFG_WAYS:       ways_q       <= cfg_data[3:0];
					CFG_BLOCK_BITS: block_bits_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (int'(ptr_q) == NUM_LINES - 1) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						base_q      <= IDX_W'(int'(set_idx) * MAX_WAYS);
						tag_q       <= in_tag;
						way_last_q  <= in_way_last;
						way_q       <= '0;
						inv_found_q <= 1'b0;
						second_q    <= (s_axis_tuser == MODE_MODIFY);
						state_q     <= (s_axis_tuser == MODE_OTHER) ? ST_SCRUB_RD : ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					inv_found_q <= inv_any;
					inv_way_q   <= inv_way;
					best_way_q  <= best_way;
					best_age_q  <= best_age;
					if (done_now) begin
						case (outcome)
							OUT_HIT:  hits_q <= sat_inc(hits_q);
							OUT_MISS: misses_q <= sat_inc(misses_q);
							default: begin
								misses_q <= sat_inc(misses_q);
								evicts_q <= sat_inc(evicts_q);
							end
						endcase
						out_valid_q   <= 1'b1;
						out_outcome_q <= outcome;
						out_last_q    <= !second_q;
						state_q       <= ST_WAIT;
					end else begin
						way_q   <= way_q + WAY_W'(1);
						state_q <= ST_READ;
					end
				end
				ST_WAIT: begin
					if (!out_valid_q) begin
						if (second_q) begin
							second_q    <= 1'b0;
							way_q       <= '0;
							inv_found_q <= 1'b0;
							state_q     <= ST_READ;
						end else begin
							state_q <= ST_SCRUB_RD;
						end
					end
				end
				ST_SCRUB_RD: begin
					state_q <= ST_SCRUB_WR;
				end
				ST_SCRUB_WR: begin
					// End of the request: every valid line ages by one.
					now_q   <= now_q + STAMP_W'(1);
					ptr_q   <= (int'(ptr_q) == NUM_LINES - 1) ? '0 : ptr_q + IDX_W'(1);
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {evicts_q, misses_q, hits_q};
	assign m_axis_tuser  = out_outcome_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_hits_mono: assert property (@(posedge clk) disable iff (!arst_n)
		hits_q >= $past(hits_q)) else $error("hit counter went backwards");
	a_miss_ge_evict: assert property (@(posedge clk) disable iff (!arst_n)
		misses_q >= evicts_q) else $error("more evictions than misses");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q != ST_IDLE) else $error("line write while idle");
	a_result_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && done_now) |-> !out_valid_q || m_axis_tready)
		else $error("result produced over a pending one");
`endif

endmodule
